>>> design/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge, reset included
`define CHK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked only while out of reset
`define CHK_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> design/bblur_pkg.sv
// shared types and constants of the 3x3 box blur
// no dependencies
package bblur_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // one window column handed from the front to the back
  typedef struct packed {
    logic   emit;
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int SUM_W  = 12;
  localparam int RCP_W  = 17;
  localparam int PROD_W = 29;
  localparam int RCP_SHIFT = 16;

  // ceil(2^16 / n), exact for sums up to 9 * 255
  localparam logic [RCP_W-1:0] RCP_1 = 17'd65536;
  localparam logic [RCP_W-1:0] RCP_2 = 17'd32768;
  localparam logic [RCP_W-1:0] RCP_3 = 17'd21846;
  localparam logic [RCP_W-1:0] RCP_4 = 17'd16384;
  localparam logic [RCP_W-1:0] RCP_6 = 17'd10923;
  localparam logic [RCP_W-1:0] RCP_9 = 17'd7282;

  function automatic logic [RCP_W-1:0] recip(input logic [3:0] count);
    logic [RCP_W-1:0] m;
    unique case (count)
      4'd2:    m = RCP_2;
      4'd3:    m = RCP_3;
      4'd4:    m = RCP_4;
      4'd6:    m = RCP_6;
      4'd9:    m = RCP_9;
      default: m = RCP_1;
    endcase
    return m;
  endfunction

endpackage

>>> design/bblur_queue.sv
// short queue of window columns between the front and the back
// depends on bblur_pkg
module bblur_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bblur_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output bblur_pkg::entry_t pop_data
);
  import bblur_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full     = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/bblur_front.sv
// front: accepts items, sorts pixels from drain ticks, runs the line stores
// depends on bblur_pkg
module bblur_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]      w_last,
  input  logic [$clog2(MAX_HEIGHT+2)-1:0]   h_last,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [7:0]                        red_in,
  input  logic [7:0]                        green_in,
  input  logic [7:0]                        blue_in,
  output logic                              push,
  output bblur_pkg::entry_t                 push_data,
  input  logic                              full
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  pixel_t line_a [MAX_WIDTH];
  pixel_t line_b [MAX_WIDTH];
  pixel_t rd_a;
  pixel_t rd_b;

  logic [CW-1:0] in_col;
  logic [CW-1:0] in_col_next;
  logic [RW-1:0] in_row;
  logic [RW-1:0] in_row_next;

  logic          s1_valid;
  pixel_t        s1_pix;
  logic [CW-1:0] s1_addr;
  logic          s1_emit;
  logic          s1_fwd;
  pixel_t        last_pix;
  pixel_t        last_a;

  logic   input_done;
  logic   skip;
  logic   take;
  logic   delay_done;
  logic   frame_done;
  logic   s1_adv;
  pixel_t new_pix;
  pixel_t a_val;
  pixel_t b_val;

  assign in_stall = s1_valid && full;
  assign s1_adv   = s1_valid && !full;

  always_comb begin
    input_done = (in_row > h_last);
    // a drain tick before the frame's input is complete does nothing
    skip       = action && !input_done;
    take       = in_valid && !in_stall && !skip;
    delay_done = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
    // the item that yields the frame's last result
    frame_done = (in_row == h_last + RW'(2));
    new_pix    = input_done ? '0 : pixel_t'{r: red_in, g: green_in, b: blue_in};

    in_col_next = in_col;
    in_row_next = in_row;
    if (take) begin
      priority if (frame_done) begin
        in_col_next = '0;
        in_row_next = '0;
      end else if (in_col == w_last) begin
        in_col_next = '0;
        in_row_next = in_row + RW'(1);
      end else begin
        in_col_next = in_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col <= '0;
      in_row <= '0;
    end else begin
      in_col <= in_col_next;
      in_row <= in_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix  <= new_pix;
      s1_addr <= in_col;
      s1_emit <= delay_done;
      // same address written at this edge, memory read returns stale data
      s1_fwd  <= s1_valid && (s1_addr == in_col);
    end
  end

  // read at acceptance, write back when the item is pushed to the queue
  always_ff @(posedge clk) begin
    if (take) begin
      rd_a <= line_a[in_col];
      rd_b <= line_b[in_col];
    end
    if (s1_adv) begin
      line_a[s1_addr] <= s1_pix;
      line_b[s1_addr] <= a_val;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      last_pix <= s1_pix;
      last_a   <= a_val;
    end
  end

  always_comb begin
    a_val = s1_fwd ? last_pix : rd_a;
    b_val = s1_fwd ? last_a : rd_b;
  end

  assign push      = s1_adv;
  assign push_data = entry_t'{emit: s1_emit, top: b_val, mid: a_val, bot: s1_pix};

endmodule

>>> design/bblur_back.sv
// back: 3x3 window, edge masks, sums, reciprocal multiply, output register
// depends on bblur_pkg
module bblur_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]    w_last,
  input  logic [$clog2(MAX_HEIGHT+2)-1:0] h_last,
  input  logic                            avail,
  input  bblur_pkg::entry_t               pop_data,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      red_out,
  output logic [7:0]                      green_out,
  output logic [7:0]                      blue_out,
  output logic                            frame_end
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  pixel_t win      [9];
  pixel_t win_next [9];

  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;

  logic             s_valid;
  logic [SUM_W-1:0] s_sum_r;
  logic [SUM_W-1:0] s_sum_g;
  logic [SUM_W-1:0] s_sum_b;
  logic [3:0]       s_count;
  logic             s_last;

  logic              m_valid;
  logic [PROD_W-1:0] m_prod_r;
  logic [PROD_W-1:0] m_prod_g;
  logic [PROD_W-1:0] m_prod_b;
  logic              m_last;

  logic en_o;
  logic en_m;
  logic en_s;
  logic emit_ok;
  logic last;
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic [1:0] rows;
  logic [1:0] cols;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [RCP_W-1:0] rcp;

  assign en_o = !out_valid || !out_stall;
  assign en_m = !m_valid || en_o;
  assign en_s = !s_valid || en_m;
  assign pop  = avail && en_s;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3 + 1] = win[r*3+2];
    end
    win_next[2] = pop_data.top;
    win_next[5] = pop_data.mid;
    win_next[8] = pop_data.bot;

    emit_ok = pop_data.emit && (out_row <= h_last);
    last    = (out_row == h_last) && (out_col == w_last);

    // neighbors outside the frame drop out of the mean
    row_ok = {out_row != h_last, 1'b1, out_row != '0};
    col_ok = {out_col != w_last, 1'b1, out_col != '0};
    rows   = 2'd1 + {1'b0, row_ok[0]} + {1'b0, row_ok[2]};
    cols   = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};

    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 9; k++) begin
      if (row_ok[k/3] && col_ok[k%3]) begin
        sum_r = sum_r + SUM_W'(win_next[k].r);
        sum_g = sum_g + SUM_W'(win_next[k].g);
        sum_b = sum_b + SUM_W'(win_next[k].b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (pop) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_col <= '0;
      out_row <= '0;
    end else if (pop && emit_ok) begin
      priority if (last) begin
        out_col <= '0;
        out_row <= '0;
      end else if (out_col == w_last) begin
        out_col <= '0;
        out_row <= out_row + RW'(1);
      end else begin
        out_col <= out_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_s) begin
        s_valid <= pop && emit_ok;
      end
      if (en_m) begin
        m_valid <= s_valid;
      end
      if (en_o) begin
        out_valid <= m_valid;
      end
    end
  end

  assign rcp = recip(s_count);

  always_ff @(posedge clk) begin
    if (en_s) begin
      s_sum_r <= sum_r;
      s_sum_g <= sum_g;
      s_sum_b <= sum_b;
      s_count <= {2'b00, rows} * {2'b00, cols};
      s_last  <= last;
    end
    if (en_m) begin
      m_prod_r <= PROD_W'(s_sum_r) * PROD_W'(rcp);
      m_prod_g <= PROD_W'(s_sum_g) * PROD_W'(rcp);
      m_prod_b <= PROD_W'(s_sum_b) * PROD_W'(rcp);
      m_last   <= s_last;
    end
    if (en_o) begin
      red_out   <= m_prod_r[RCP_SHIFT +: 8];
      green_out <= m_prod_g[RCP_SHIFT +: 8];
      blue_out  <= m_prod_b[RCP_SHIFT +: 8];
      frame_end <= m_last;
    end
  end

endmodule

>>> design/box_blur_3x3_edge_average_core.sv
// top level of the 3x3 edge-aware box blur: register port, front, queue, back
// depends on bblur_pkg, bblur_front, bblur_queue, bblur_back
//
// channel  signals                                              role
// in       in_valid in_stall action red_in green_in blue_in      pixels and drain ticks
// out      out_valid out_stall red_out green_out blue_out frame_end  blurred pixels
// cfg      psel penable pwrite paddr pwdata prdata pready        frame_width, frame_height
//
// one item per clock sustained while in_stall is low; each item does one read and one write in each line store
// a result passes the queue and the sum, product and output registers, one row plus one pixel behind its item
// reset clears counters, window and handshake state; line stores are not cleared
// out_stall holds the back pipeline, a 4-entry queue absorbs it, then in_stall rises
module box_blur_3x3_edge_average_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic        cfg_wr;
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  logic   push;
  logic   full;
  logic   pop;
  logic   avail;
  entry_t push_data;
  entry_t pop_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[10:0];
        REG_HEIGHT: frame_height <= pwdata[12:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // zero reads as one, oversize saturates to the build limit
  always_comb begin
    priority if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (frame_width > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    priority if (frame_height == '0) begin
      eff_h = RW'(1);
    end else if (frame_height > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(frame_height);
    end
    w_last = CW'(eff_w - WW'(1));
    h_last = eff_h - RW'(1);
  end

  bblur_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .w_last    (w_last),
    .h_last    (h_last),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  bblur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  bblur_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .w_last    (w_last),
    .h_last    (h_last),
    .avail     (avail),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
  );

endmodule

>>> design/bblur_checker.sv
// port-level checks of the box blur core, attached by bind
// depends on assert_macros.svh
`include "assert_macros.svh"

module bblur_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic       frame_end
);

  `CHK_ALWAYS(a_rst_no_out, clk, rst |=> !out_valid, "result shown right after reset")
  `CHK_ALWAYS(a_rst_no_stall, clk, rst |=> !in_stall, "input stalled right after reset")
  `CHK_RUN(a_out_held, clk, rst, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `CHK_RUN(a_out_stable, clk, rst,
           out_valid && out_stall |=> $stable({red_out, green_out, blue_out, frame_end}),
           "stalled result changed")

endmodule

bind box_blur_3x3_edge_average_core bblur_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out),
  .frame_end (frame_end)
);

>>> verif/box_blur_3x3_edge_average_check.sv
`timescale 1ns / 100ps
// scoreboard for the 3x3 edge-aware box blur: tracks frame position, line rows and window,
// predicts every blurred pixel and compares the output transfers with it in order
// depends on bblur_pkg (pixel_t)
module box_blur_3x3_edge_average_check #(
  parameter int         MAX_WIDTH   = 1024,
  parameter int         MAX_HEIGHT  = 4096,
  parameter logic [2:0] WIDTH_ADDR  = 3'd0,
  parameter logic [2:0] HEIGHT_ADDR = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        is_drain,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  red_out,
  input  logic [7:0]  green_out,
  input  logic [7:0]  blue_out,
  input  logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          results
);
  import bblur_pkg::*;

  localparam logic [10:0] WIDTH_AT_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_AT_RESET = 13'd480;
  localparam int          REPORT_LIMIT    = 10;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } blurred_t;

  logic [10:0] width_reg;
  logic [12:0] height_reg;
  pixel_t      above [MAX_WIDTH];   // row just above the incoming pixel
  pixel_t      above2 [MAX_WIDTH];  // two rows above
  pixel_t      win [9];             // [row * 3 + col], oldest column on the left
  int          col_in, row_in, col_out, row_out;
  blurred_t    blurred_q [$];
  int          n_bad = 0;
  int          n_seen = 0;

  function automatic int clip(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  // one accepted item: shift the window, update line rows, maybe emit a blurred pixel
  function automatic void blur_step(input logic drain, input pixel_t px_in);
    int       w, h, x, rr, cc, cnt;
    int       sum [3];
    logic     done_in, primed;
    pixel_t   px, v;
    blurred_t res;
    w = clip(int'(width_reg), MAX_WIDTH);
    h = clip(int'(height_reg), MAX_HEIGHT);
    done_in = row_in >= h;
    if (drain && !done_in) return;
    // past the frame's input any item is a drain tick and carries zero
    px = done_in ? '0 : px_in;
    x = col_in % MAX_WIDTH;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = above2[x];
    win[5] = above[x];
    win[8] = px;
    above2[x] = above[x];
    above[x]  = px;
    primed = row_in >= 2 || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (!primed || row_out >= h) return;
    sum = '{0, 0, 0};
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = row_out + dr;
        cc = col_out + dc;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          v = win[(dr + 1) * 3 + dc + 1];
          sum[0] += int'(v.r);
          sum[1] += int'(v.g);
          sum[2] += int'(v.b);
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.px.r = 8'(sum[0] / cnt);
    res.px.g = 8'(sum[1] / cnt);
    res.px.b = 8'(sum[2] / cnt);
    res.last = row_out == h - 1 && col_out == w - 1;
    blurred_q.push_back(res);
    if (res.last) begin
      restart();
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    blurred_t want;
    if (rst) begin
      width_reg  = WIDTH_AT_RESET;
      height_reg = HEIGHT_AT_RESET;
      foreach (above[i]) begin
        above[i]  = '0;
        above2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      restart();
      blurred_q.delete();
    end else begin
      // a register write restarts the frame at once
      if (psel && penable && pwrite && pready) begin
        if (paddr == WIDTH_ADDR) begin
          width_reg = pwdata[10:0];
          restart();
        end else if (paddr == HEIGHT_ADDR) begin
          height_reg = pwdata[12:0];
          restart();
        end
      end
      if (in_valid && !in_stall) blur_step(is_drain, {red_in, green_in, blue_in});
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("unexpected blurred pixel: got rgb %0d %0d %0d end %0b",
                     red_out, green_out, blue_out, frame_end);
        end else begin
          want = blurred_q.pop_front();
          n_seen++;
          if (want.px.r !== red_out || want.px.g !== green_out ||
              want.px.b !== blue_out || want.last !== frame_end) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT)
              $display("blurred pixel %0d: expected rgb %0d %0d %0d end %0b, got %0d %0d %0d end %0b",
                       n_seen, want.px.r, want.px.g, want.px.b, want.last,
                       red_out, green_out, blue_out, frame_end);
          end
        end
      end
    end
    pending    <= blurred_q.size();
    results    <= n_seen;
    mismatches <= n_bad;
  end

endmodule

>>> verif/box_blur_3x3_edge_average_core_test.sv
`timescale 1ns / 100ps
// testbench top for the 3x3 edge-aware box blur: clock, reset, register writes,
// pixel and drain stimulus, output stall, watchdog and verdict
// depends on box_blur_3x3_edge_average_core and box_blur_3x3_edge_average_check
module box_blur_3x3_edge_average_core_test;

  localparam int         FRAME_W_MAX  = 1024;
  localparam int         FRAME_H_MAX  = 4096;
  localparam logic [2:0] WIDTH_ADDR   = 3'd0;
  localparam logic [2:0] HEIGHT_ADDR  = 3'd4;
  localparam logic       PIXEL        = 1'b0;
  localparam logic       DRAIN        = 1'b1;
  localparam int         RANDOM_ITEMS = 260;
  localparam int         WIDE_FLUSH   = 8;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         SETTLE_PAD   = 12;
  localparam int         END_PAD      = 20;

  typedef enum int {NO_IDLE, TX_IDLE, RX_IDLE, BOTH_IDLE} idle_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        action = 1'b0;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        in_stall, out_valid, frame_end, pready;
  logic [7:0]  red_out, green_out, blue_out;
  logic [31:0] prdata;
  int          mismatches, pending, results;

  idle_t idle_mode = NO_IDLE;
  bit    hold_req = 1'b0;
  int    cur_w = 1;
  int    cur_h = 1;
  int    n_pixels = 0;
  int    n_drains = 0;
  int    n_ignored = 0;
  int    n_settings = 0;
  int    n_abandoned = 0;

  always #5 clk = ~clk;

  box_blur_3x3_edge_average_core #(
    .MAX_WIDTH (FRAME_W_MAX),
    .MAX_HEIGHT(FRAME_H_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out),
    .frame_end(frame_end),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  box_blur_3x3_edge_average_check #(
    .MAX_WIDTH  (FRAME_W_MAX),
    .MAX_HEIGHT (FRAME_H_MAX),
    .WIDTH_ADDR (WIDTH_ADDR),
    .HEIGHT_ADDR(HEIGHT_ADDR)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .is_drain  (action),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .mismatches(mismatches),
    .pending   (pending),
    .results   (results)
  );

  function automatic bit roll_idle(input bit rx);
    if (idle_mode == BOTH_IDLE) return $urandom_range(99) < 8;
    if (idle_mode == (rx ? RX_IDLE : TX_IDLE)) return $urandom_range(99) < 52;
    return 1'b0;
  endfunction

  // channel values lean toward the extremes
  function automatic logic [7:0] rnd_level();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int clip(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // output side: random stall, or a long hold while the input keeps coming
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= roll_idle(1'b1);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic offer(input logic act, input logic [7:0] r, input logic [7:0] g,
                       input logic [7:0] b);
    while (roll_idle(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    offer(PIXEL, r, g, b);
    n_pixels++;
  endtask

  // drain tick the block drops: frame input not complete or frame already out
  task automatic idle_drain();
    offer(DRAIN, rnd_level(), rnd_level(), rnd_level());
    n_ignored++;
  endtask

  // items after the frame's input; a pixel here counts as a drain tick
  task automatic flush_frame(input int n);
    for (int k = 0; k < n; k++) begin
      offer(($urandom_range(99) < 25) ? PIXEL : DRAIN, rnd_level(), rnd_level(), rnd_level());
      n_drains++;
    end
  endtask

  // stop offering and wait for every expected pixel
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
    settle();
    // the block may still hold items that cause no result
    repeat (SETTLE_PAD) @(posedge clk);
    if ($urandom_range(1)) begin
      write_reg(WIDTH_ADDR, w_raw);
      write_reg(HEIGHT_ADDR, h_raw);
    end else begin
      write_reg(HEIGHT_ADDR, h_raw);
      write_reg(WIDTH_ADDR, w_raw);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_w = clip(int'(w_raw & 32'h7ff), FRAME_W_MAX);
    cur_h = clip(int'(h_raw & 32'h1fff), FRAME_H_MAX);
    n_settings++;
  endtask

  // one frame of random pixels; cut below the pixel count abandons the frame there
  task automatic send_frame(input int cut);
    int total, pause_at;
    total = cur_w * cur_h;
    pause_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : -1;
    for (int i = 0; i < total && i < cut; i++) begin
      if ($urandom_range(99) < 3) idle_drain();
      send_pixel(rnd_level(), rnd_level(), rnd_level());
      if (i == pause_at) settle();
    end
    // the last row plus one pixel come out on drain ticks
    if (cut < total) n_abandoned++;
    else flush_frame(cur_w + 1);
  endtask

  initial begin : stimulus
    int w_raw, h_raw, cut, total, start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame: corners, edges and center, extreme channel values
    set_frame(3, 3);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    idle_drain();
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h7f, 8'h01);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hfe, 8'hfd, 8'hfc);
    offer(PIXEL, 8'hab, 8'hcd, 8'hef);
    n_drains++;
    flush_frame(cur_w);
    idle_drain();
    // zero size reads as a single pixel
    set_frame(0, 0);
    send_pixel(8'hff, 8'hff, 8'hff);
    flush_frame(cur_w + 1);

    // block fills up behind a long output hold
    set_frame(16, 8);
    hold_req = 1'b1;
    send_frame(cur_w * cur_h);
    // oversized width saturates: one full-width row, then the first few results
    set_frame(2047, 1);
    for (int i = 0; i < cur_w; i++) send_pixel(rnd_level(), rnd_level(), rnd_level());
    flush_frame(WIDE_FLUSH);
    n_abandoned++;
    // oversized height saturates: start a tall column, then abandon it
    set_frame(1, 8191);
    send_frame(40);

    start = n_pixels + n_drains;
    while (n_pixels + n_drains - start < RANDOM_ITEMS) begin
      idle_mode = idle_t'(((n_pixels + n_drains - start) * 4) / RANDOM_ITEMS);
      case ($urandom_range(9))
        0:       w_raw = 0;
        1, 2:    w_raw = $urandom_range(40, 9);
        default: w_raw = $urandom_range(8, 1);
      endcase
      case ($urandom_range(9))
        0:       h_raw = 0;
        1, 2:    h_raw = $urandom_range(16, 7);
        default: h_raw = $urandom_range(6, 1);
      endcase
      set_frame(w_raw, h_raw);
      total = cur_w * cur_h;
      cut = total;
      if (total > 1 && $urandom_range(99) < 12) cut = $urandom_range(total - 1, 1);
      send_frame(cut);
      if ($urandom_range(99) < 10) idle_drain();
    end

    settle();
    repeat (END_PAD) @(posedge clk);
    $display("sent %0d pixels, %0d drain ticks and %0d ignored ticks over %0d frame settings",
             n_pixels, n_drains, n_ignored, n_settings);
    $display("checked %0d blurred pixels; %0d frames abandoned; four idle patterns, one long hold",
             results, n_abandoned);
    if (pending != 0) $display("%0d expected blurred pixels never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
